// ===== rtl/gbp_pkg.sv =====
// -----------------------------------------------------------------------------
// gbp_pkg
// Types, constants and helper functions shared by the gshare predictor files.
// -----------------------------------------------------------------------------
package gbp_pkg;

	localparam int ADDR_W      = 32;
	localparam int TOTAL_W     = 32;
	localparam int HIST_W      = 11;
	localparam int HLEN_W      = 4;
	localparam int CTR_W       = 2;

	localparam logic [HLEN_W-1:0] HIST_MIN   = 4'd3;
	localparam logic [HLEN_W-1:0] HIST_MAX   = 4'd11;
	localparam logic [HLEN_W-1:0] HIST_RESET = 4'd8;
	localparam logic [CTR_W-1:0]  CTR_RESET  = 2'd3;
	localparam logic [CTR_W-1:0]  CTR_MAX    = 2'd3;
	localparam logic [CTR_W-1:0]  CTR_MIN    = 2'd0;

	// Result queue.
	localparam int OUT_DEPTH   = 16;
	localparam int OUT_PTR_W   = 4;
	localparam int USED_W      = 5;

	// Configuration port.
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam int REG_IDX_W   = 1;
	localparam logic [REG_IDX_W-1:0] REG_HIST_LEN = 1'b0;

	typedef struct packed {
		logic valid;
		logic taken;
	} item_ctl_t;

	typedef struct packed {
		logic valid;
		logic pred;
		logic ok;
	} tbl_res_t;

	typedef struct packed {
		logic               pred;
		logic               ok;
		logic [TOTAL_W-1:0] total;
	} out_item_t;

	// History mask for a programmed length, clamped to the supported range.
	function automatic logic [HIST_W-1:0] hist_mask(input logic [HLEN_W-1:0] len);
		logic [HLEN_W-1:0] l;
		logic [HIST_W:0]   one_hot;
		l = len;
		if (l < HIST_MIN) begin
			l = HIST_MIN;
		end
		if (l > HIST_MAX) begin
			l = HIST_MAX;
		end
		one_hot = (HIST_W+1)'(1) << l;
		hist_mask = HIST_W'(one_hot - (HIST_W+1)'(1));
	endfunction

endpackage

// ===== rtl/gbp_if.sv =====
// -----------------------------------------------------------------------------
// gbp_if
// Valid/ready channels for branch items and prediction result items.
// -----------------------------------------------------------------------------
interface gbp_in_if;
	logic                       valid;
	logic                       ready;
	logic [gbp_pkg::ADDR_W-1:0] branch_address;
	logic                       branch_taken;

	modport source (output valid, output branch_address, output branch_taken, input ready);
	modport sink   (input valid, input branch_address, input branch_taken, output ready);
endinterface

interface gbp_out_if;
	logic                        valid;
	logic                        ready;
	logic                        predicted_taken;
	logic                        prediction_correct;
	logic [gbp_pkg::TOTAL_W-1:0] correct_total;

	modport source (output valid, output predicted_taken, output prediction_correct,
		output correct_total, input ready);
	modport sink   (input valid, input predicted_taken, input prediction_correct,
		input correct_total, output ready);
endinterface

// ===== rtl/gbp_index.sv =====
// -----------------------------------------------------------------------------
// gbp_index
// Reduces the hashed address modulo the table size. A power-of-two table takes
// the low bits directly; any other size runs a three-stage reciprocal unit.
// -----------------------------------------------------------------------------
module gbp_index #(
	parameter int N = 2048
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gbp_pkg::item_ctl_t         in_ctl,
	input  logic [gbp_pkg::ADDR_W-1:0] in_raw,
	output gbp_pkg::item_ctl_t         out_ctl,
	output logic [$clog2(N)-1:0]       out_idx
);

	localparam int IW   = $clog2(N);
	localparam bit POW2 = ((N & (N - 1)) == 0);

	generate
		if (POW2) begin : g_pow2
			assign out_ctl = in_ctl;
			assign out_idx = in_raw[IW-1:0];
		end else begin : g_mod
			localparam logic [gbp_pkg::ADDR_W-1:0] MOD   = gbp_pkg::ADDR_W'(N);
			localparam logic [gbp_pkg::ADDR_W-1:0] RECIP =
				gbp_pkg::ADDR_W'(64'h1_0000_0000 / 64'(N));

			gbp_pkg::item_ctl_t         ctl_s1;
			gbp_pkg::item_ctl_t         ctl_s2;
			gbp_pkg::item_ctl_t         ctl_s3;
			logic [gbp_pkg::ADDR_W-1:0] raw_s1;
			logic [gbp_pkg::ADDR_W-1:0] quo_s1;
			logic [gbp_pkg::ADDR_W-1:0] rem_s2;
			logic [IW-1:0]              rem_s3;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					ctl_s1 <= '0;
					ctl_s2 <= '0;
					ctl_s3 <= '0;
				end else begin
					ctl_s1 <= in_ctl;
					ctl_s2 <= ctl_s1;
					ctl_s3 <= ctl_s2;
				end
			end

			// The quotient estimate from the truncated reciprocal is at most one
			// short, so the first remainder lies below twice the modulus and a
			// single compare and subtract finishes it.
			always_ff @(posedge clk) begin
				raw_s1 <= in_raw;
				quo_s1 <= gbp_pkg::ADDR_W'(((2*gbp_pkg::ADDR_W)'(in_raw)
					* (2*gbp_pkg::ADDR_W)'(RECIP)) >> gbp_pkg::ADDR_W);
				rem_s2 <= raw_s1 - quo_s1 * MOD;
				rem_s3 <= IW'((rem_s2 >= MOD) ? (rem_s2 - MOD) : rem_s2);
			end

			assign out_ctl = ctl_s3;
			assign out_idx = rem_s3;
		end
	endgenerate

endmodule

// ===== rtl/gbp_table.sv =====
// -----------------------------------------------------------------------------
// gbp_table
// Counter table in a synchronous RAM: read, predict, update and write back,
// with forwarding from the previous write. Fills the RAM after reset.
// -----------------------------------------------------------------------------
module gbp_table #(
	parameter int N = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gbp_pkg::item_ctl_t   in_ctl,
	input  logic [$clog2(N)-1:0] in_idx,
	output logic                 busy,
	output gbp_pkg::tbl_res_t    res
);

	localparam int IW = $clog2(N);

	logic [gbp_pkg::CTR_W-1:0] ctr_mem [N];

	logic                      clr_busy_q;
	logic [IW-1:0]             clr_idx_q;

	gbp_pkg::item_ctl_t        ctl_s1;
	logic [IW-1:0]             idx_s1;
	logic [gbp_pkg::CTR_W-1:0] rd_data_s1;

	gbp_pkg::tbl_res_t         res_s2;
	logic [IW-1:0]             wb_idx_s2;
	logic [gbp_pkg::CTR_W-1:0] wb_ctr_s2;

	logic [gbp_pkg::CTR_W-1:0] ctr_cur;
	logic [gbp_pkg::CTR_W-1:0] ctr_new;
	logic                      pred;
	logic                      wr_en;
	logic [IW-1:0]             wr_addr;
	logic [gbp_pkg::CTR_W-1:0] wr_data;

	// The item one ahead wrote its counter at the edge this item read, so the
	// RAM still returned the old value for a shared entry.
	always_comb begin
		if (res_s2.valid && (wb_idx_s2 == idx_s1)) begin
			ctr_cur = wb_ctr_s2;
		end else begin
			ctr_cur = rd_data_s1;
		end
		pred = ctr_cur[1];
		ctr_new = ctr_cur;
		if (ctl_s1.taken) begin
			if (ctr_cur != gbp_pkg::CTR_MAX) begin
				ctr_new = ctr_cur + gbp_pkg::CTR_W'(1);
			end
		end else begin
			if (ctr_cur != gbp_pkg::CTR_MIN) begin
				ctr_new = ctr_cur - gbp_pkg::CTR_W'(1);
			end
		end
	end

	always_comb begin
		wr_en   = clr_busy_q || ctl_s1.valid;
		wr_addr = clr_busy_q ? clr_idx_q : idx_s1;
		wr_data = clr_busy_q ? gbp_pkg::CTR_RESET : ctr_new;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ctr_mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= ctr_mem[in_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + IW'(1);
			if (clr_idx_q == IW'(N - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			res_s2 <= '0;
		end else begin
			ctl_s1.valid <= in_ctl.valid;
			ctl_s1.taken <= in_ctl.taken;
			res_s2.valid <= ctl_s1.valid;
			res_s2.pred  <= pred;
			res_s2.ok    <= (pred == ctl_s1.taken);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1       <= in_idx;
		wb_idx_s2    <= idx_s1;
		wb_ctr_s2    <= ctr_new;
	end

	assign busy = clr_busy_q;
	assign res  = res_s2;

endmodule

// ===== rtl/gshare_branch_predictor.sv =====
// -----------------------------------------------------------------------------
// gshare_branch_predictor
// Global-history branch predictor with a 2-bit counter table and a running
// count of correct predictions.
// -----------------------------------------------------------------------------
// The block takes one branch item per cycle unless it is filling the RAM or
// out of result-queue credit, and returns one result item per branch, in
// order. An item passes the intake register, the remainder unit if TABLE_ENTRIES
// is not a power of two (it adds three stages), the table's read and result
// registers and the result queue. The rate is set by the counter RAM, read and
// written once per item; back-to-back branches to the same entry are served by
// forwarding. After reset the RAM is filled with the strongly taken state,
// during which no item is accepted; configuration writes are taken at any time.
// A 16-entry result queue lets the block keep accepting while results wait.
module gshare_branch_predictor #(
	parameter int TABLE_ENTRIES = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	gbp_in_if.sink                         branch,
	gbp_out_if.source                      result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gbp_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [gbp_pkg::APB_DATA_W-1:0] pwdata,
	output logic [gbp_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);

	localparam int IW = $clog2(TABLE_ENTRIES);

	logic [gbp_pkg::HLEN_W-1:0]    hist_len_q;
	logic [gbp_pkg::HIST_W-1:0]    ghist_q;
	logic [gbp_pkg::HIST_W-1:0]    mask;
	logic [gbp_pkg::HIST_W-1:0]    hist_used;
	logic [gbp_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          cfg_wr;

	logic                          in_acc;
	logic                          out_acc;
	logic                          busy;

	gbp_pkg::item_ctl_t            ctl_s1;
	logic [gbp_pkg::ADDR_W-1:0]    raw_s1;

	gbp_pkg::item_ctl_t            idx_ctl;
	logic [IW-1:0]                 idx;
	gbp_pkg::tbl_res_t             res;

	logic [gbp_pkg::TOTAL_W-1:0]   correct_q;
	logic [gbp_pkg::TOTAL_W-1:0]   total_nx;

	gbp_pkg::out_item_t            fifo_mem [gbp_pkg::OUT_DEPTH];
	logic [gbp_pkg::OUT_PTR_W-1:0] wr_ptr_q;
	logic [gbp_pkg::OUT_PTR_W-1:0] rd_ptr_q;
	logic [gbp_pkg::USED_W-1:0]    fifo_cnt_q;
	logic [gbp_pkg::USED_W-1:0]    used_q;

	// Configuration port.
	assign reg_idx = paddr[gbp_pkg::APB_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && (reg_idx == gbp_pkg::REG_HIST_LEN);
	assign pready  = 1'b1;

	always_comb begin
		case (reg_idx)
			gbp_pkg::REG_HIST_LEN: prdata = gbp_pkg::APB_DATA_W'(hist_len_q);
			default:               prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_len_q <= gbp_pkg::HIST_RESET;
		end else if (cfg_wr) begin
			hist_len_q <= pwdata[gbp_pkg::HLEN_W-1:0];
		end
	end

	// Intake. Credits cover every item between acceptance and delivery, so the
	// result queue can never overflow.
	assign branch.ready = !busy && (used_q < gbp_pkg::USED_W'(gbp_pkg::OUT_DEPTH));
	assign in_acc       = branch.valid && branch.ready;
	assign out_acc      = result.valid && result.ready;

	assign mask      = gbp_pkg::hist_mask(hist_len_q);
	assign hist_used = ghist_q & mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ghist_q <= '0;
			ctl_s1  <= '0;
		end else begin
			ctl_s1.valid <= in_acc;
			ctl_s1.taken <= branch.branch_taken;
			if (in_acc) begin
				ghist_q <= {ghist_q[gbp_pkg::HIST_W-2:0], branch.branch_taken} & mask;
			end
		end
	end

	always_ff @(posedge clk) begin
		raw_s1       <= branch.branch_address ^ gbp_pkg::ADDR_W'(hist_used);
	end

	gbp_index #(
		.N (TABLE_ENTRIES)
	) u_index (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (ctl_s1),
		.in_raw  (raw_s1),
		.out_ctl (idx_ctl),
		.out_idx (idx)
	);

	gbp_table #(
		.N (TABLE_ENTRIES)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ctl (idx_ctl),
		.in_idx (idx),
		.busy   (busy),
		.res    (res)
	);

	// Running count of correct predictions, held at its maximum once full.
	assign total_nx = correct_q
		+ gbp_pkg::TOTAL_W'(res.ok && (correct_q != {gbp_pkg::TOTAL_W{1'b1}}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			correct_q <= '0;
		end else if (res.valid) begin
			correct_q <= total_nx;
		end
	end

	// Result queue.
	always_ff @(posedge clk) begin
		if (res.valid) begin
			fifo_mem[wr_ptr_q] <= '{pred: res.pred, ok: res.ok, total: total_nx};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			used_q     <= '0;
		end else begin
			if (res.valid) begin
				wr_ptr_q <= wr_ptr_q + gbp_pkg::OUT_PTR_W'(1);
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + gbp_pkg::OUT_PTR_W'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + gbp_pkg::USED_W'(res.valid)
				- gbp_pkg::USED_W'(out_acc);
			used_q <= used_q + gbp_pkg::USED_W'(in_acc) - gbp_pkg::USED_W'(out_acc);
		end
	end

	assign result.valid              = (fifo_cnt_q != '0);
	assign result.predicted_taken    = fifo_mem[rd_ptr_q].pred;
	assign result.prediction_correct = fifo_mem[rd_ptr_q].ok;
	assign result.correct_total      = fifo_mem[rd_ptr_q].total;

endmodule

// ===== rtl/gbp_checker.sv =====
// -----------------------------------------------------------------------------
// gbp_checker
// Port-level checks for the gshare predictor, bound to the top level.
// -----------------------------------------------------------------------------
module gbp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        out_pred,
	input logic                        out_ok,
	input logic [gbp_pkg::TOTAL_W-1:0] out_total
);

	logic [gbp_pkg::TOTAL_W-1:0] last_total_q;
	logic [5:0]                  pending_q;
	logic                        in_acc;
	logic                        out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_total_q <= '0;
			pending_q    <= '0;
		end else begin
			if (out_acc) begin
				last_total_q <= out_total;
			end
			pending_q <= pending_q + 6'(in_acc) - 6'(out_acc);
		end
	end

	// Each result moves the count by its own correctness flag, unless full.
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (({1'b0, out_total} == {1'b0, last_total_q} + 33'(out_ok))
			|| ((last_total_q == {gbp_pkg::TOTAL_W{1'b1}})
			&& (out_total == {gbp_pkg::TOTAL_W{1'b1}}))))
		else $error("correct_total does not follow prediction_correct");

	// No result without an accepted branch still owed a result.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending_q != '0))
		else $error("result offered with no branch outstanding");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result valid dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(out_pred) && $stable(out_ok)
			&& $stable(out_total)))
		else $error("result payload changed while stalled");

endmodule

bind gshare_branch_predictor gbp_checker u_gbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (branch.valid),
	.in_ready  (branch.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_pred  (result.predicted_taken),
	.out_ok    (result.prediction_correct),
	.out_total (result.correct_total)
);
